// ----- hw/rtl/c3ks_pkg.sv -----
`default_nettype none
package c3ks_pkg;

  localparam int KSIZE  = 3;
  localparam int KTAPS  = 9;
  localparam int PIX_W  = 8;
  localparam int COEF_W = 16;
  localparam int CFG_W  = 48;
  localparam int WID_W  = 12;
  localparam int HGT_W  = 16;
  localparam int PROD_W = 25;
  localparam int ACC_W  = 28;
  localparam int KS_W   = 20;

  localparam logic [2:0] CFG_COEF_TOP = 3'd0;
  localparam logic [2:0] CFG_COEF_MID = 3'd1;
  localparam logic [2:0] CFG_COEF_BOT = 3'd2;
  localparam logic [2:0] CFG_WIDTH    = 3'd3;
  localparam logic [2:0] CFG_HEIGHT   = 3'd4;

  localparam logic [CFG_W-1:0] RST_COEF_TOP = 48'd4295098369;
  localparam logic [CFG_W-1:0] RST_COEF_MID = 48'd8590196738;
  localparam logic [CFG_W-1:0] RST_COEF_BOT = 48'd4295098369;
  localparam logic [WID_W-1:0] RST_WIDTH    = 12'd640;
  localparam logic [HGT_W-1:0] RST_HEIGHT   = 16'd480;

  // one window: nine masked pixels (row-major, top-left first) and output selects
  typedef struct packed {
    logic [KTAPS-1:0][PIX_W-1:0] pix;
    logic [1:0]                  rows_on;
    logic [1:0]                  cols_on;
  } job_t;

  typedef enum logic {
    F_IDLE,
    F_READ
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MAC,
    B_CHK,
    B_DIV,
    B_OUT
  } back_state_e;

endpackage
`default_nettype wire

// ----- hw/rtl/c3ks_ram.sv -----
`default_nettype none
module c3ks_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- hw/rtl/c3ks_front.sv -----
`default_nettype none
module c3ks_front #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    push_i,
  output logic                         full_o,
  input  wire logic [7:0]              pixel_i,
  input  wire logic                    geom_clr_i,
  input  wire logic [11:0]             width_i,
  input  wire logic [15:0]             height_i,
  input  wire logic                    fifo_full_i,
  output logic                         job_push_o,
  output c3ks_pkg::job_t               job_o
);
  import c3ks_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int WW = (CW > WID_W) ? CW : WID_W;

  front_state_e st_q, st_d;
  logic         accept;
  logic [7:0]   pix_q;
  logic [WW-1:0] col_q, w_ext, w_eff;
  logic [HGT_W-1:0] row_q, h_eff;
  logic [23:0]  win0_q, win1_q, cur;
  logic [15:0]  rd_data;
  logic [AW-1:0] idx;
  logic         rv0, rv1, cv0, cv1;
  logic [WW:0]  col_inc;
  logic [HGT_W:0] row_inc;

  assign w_ext = WW'(width_i);
  assign w_eff = (w_ext == '0) ? WW'(1) :
                 (w_ext > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : w_ext;
  assign h_eff = (height_i == '0) ? HGT_W'(1) : height_i;
  assign idx   = col_q[AW-1:0];

  // line buffer: [7:0] row r-2, [15:8] row r-1
  c3ks_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_lines (
    .clk_i   (clk_i),
    .we_i    (st_q == F_READ),
    .waddr_i (idx),
    .wdata_i ({pix_q, rd_data[15:8]}),
    .raddr_i (idx),
    .rdata_o (rd_data)
  );

  always_comb begin
    st_d = st_q;
    case (st_q)
      F_IDLE:  if (push_i && !fifo_full_i) st_d = F_READ;
      F_READ:  st_d = F_IDLE;
      default: st_d = F_IDLE;
    endcase
  end

  always_comb begin
    full_o     = 1'b1;
    job_push_o = 1'b0;
    case (st_q)
      F_IDLE:  full_o = fifo_full_i;
      F_READ:  job_push_o = 1'b1;
      default: full_o = 1'b1;
    endcase
  end

  assign accept = push_i && !full_o;
  assign cur    = {pix_q, rd_data};
  assign rv0    = row_q >= HGT_W'(2);
  assign rv1    = row_q >= HGT_W'(1);
  assign cv0    = col_q >= WW'(2);
  assign cv1    = col_q >= WW'(1);
  assign col_inc = {1'b0, col_q} + (WW+1)'(1);
  assign row_inc = {1'b0, row_q} + (HGT_W+1)'(1);

  always_comb begin
    for (int i = 0; i < KSIZE; i++) begin
      job_o.pix[i*KSIZE+0] = (((i == 2) || (i == 1 && rv1) || (i == 0 && rv0)) && cv0) ?
                             win1_q[8*i +: 8] : 8'd0;
      job_o.pix[i*KSIZE+1] = (((i == 2) || (i == 1 && rv1) || (i == 0 && rv0)) && cv1) ?
                             win0_q[8*i +: 8] : 8'd0;
      job_o.pix[i*KSIZE+2] = ((i == 2) || (i == 1 && rv1) || (i == 0 && rv0)) ?
                             cur[8*i +: 8] : 8'd0;
    end
    job_o.rows_on = {row_q == h_eff - HGT_W'(1), rv1};
    job_o.cols_on = {col_q == w_eff - WW'(1), cv1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= F_IDLE;
      col_q  <= '0;
      row_q  <= '0;
      win0_q <= '0;
      win1_q <= '0;
    end else begin
      st_q <= st_d;
      if (geom_clr_i) begin
        col_q <= '0;
        row_q <= '0;
      end else if (st_q == F_READ) begin
        win1_q <= win0_q;
        win0_q <= cur;
        if (col_inc >= {1'b0, w_eff}) begin
          col_q <= '0;
          row_q <= (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[HGT_W-1:0];
        end else begin
          col_q <= col_inc[WW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q <= pixel_i;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/c3ks_job_fifo.sv -----
`default_nettype none
module c3ks_job_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_i,
  input  c3ks_pkg::job_t      wdata_i,
  output logic                full_o,
  input  wire logic           rd_i,
  output c3ks_pkg::job_t      rdata_o,
  output logic                valid_o
);
  import c3ks_pkg::*;

  job_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= ~wp_q;
      if (rd_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(wr_i) - 2'(rd_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/c3ks_back.sv -----
`default_nettype none
module c3ks_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [47:0] coef_top_i,
  input  wire logic [47:0] coef_mid_i,
  input  wire logic [47:0] coef_bot_i,
  input  wire logic        job_valid_i,
  input  c3ks_pkg::job_t   job_i,
  output logic             job_pop_o,
  output logic             out_valid_o,
  input  wire logic        out_pop_i,
  output logic [7:0]       pixel_o,
  output logic             zero_sum_o,
  output logic             clipped_o,
  output logic             last_o,
  output logic             frame_end_o
);
  import c3ks_pkg::*;

  back_state_e st_q, st_d;
  job_t        job_q;
  logic [1:0]  p_q, m_q, n_q;
  logic [3:0]  s_q;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [KS_W-1:0]   ks_q;
  logic [ACC_W-1:0] rem_q, dsr_q, abs_a, abs_k, rem_sub;
  logic [7:0]  quo_q, quo_d;
  logic [2:0]  bc_q;
  logic [7:0]  px_q;
  logic        zs_q, cl_q;
  logic [3:0]  en_job, en_in;
  logic [1:0]  first_p, next_p;
  logic        any_in, has_next;
  logic [47:0] row_coefs;
  logic signed [COEF_W-1:0] coef;
  logic [1:0]  rr, cc;
  logic [3:0]  pidx;
  logic signed [8:0] pixs;
  logic        neg, out_free, load_out;

  function automatic logic [3:0] enables(input logic [1:0] rows, input logic [1:0] cols);
    logic [3:0] e;
    for (int i = 0; i < 4; i++) e[i] = rows[i/2] & cols[i%2];
    return e;
  endfunction

  assign en_in  = enables(job_i.rows_on, job_i.cols_on);
  assign en_job = enables(job_q.rows_on, job_q.cols_on);
  assign any_in = |en_in;

  always_comb begin
    first_p  = 2'd0;
    next_p   = 2'd0;
    has_next = 1'b0;
    for (int i = 3; i >= 0; i--) begin
      if (en_in[i]) first_p = 2'(i);
      if (en_job[i] && 2'(i) > p_q) begin
        next_p   = 2'(i);
        has_next = 1'b1;
      end
    end
  end

  always_comb begin
    case (m_q)
      2'd0:    row_coefs = coef_top_i;
      2'd1:    row_coefs = coef_mid_i;
      default: row_coefs = coef_bot_i;
    endcase
  end

  assign coef   = row_coefs[16*n_q +: 16];
  assign rr     = p_q[1] + m_q;
  assign cc     = p_q[0] + n_q;
  assign pidx   = {2'b0, rr} * 4'd3 + {2'b0, cc};
  assign pixs   = (rr != 2'd3 && cc != 2'd3) ? {1'b0, job_q.pix[pidx]} : 9'sd0;
  assign prod_d = coef * pixs;

  assign abs_a   = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign abs_k   = ks_q[KS_W-1] ? ACC_W'(-ks_q) : ACC_W'(ks_q);
  assign neg     = acc_q[ACC_W-1] ^ ks_q[KS_W-1];
  assign rem_sub = rem_q - dsr_q;
  always_comb begin
    quo_d = quo_q;
    quo_d[bc_q] = rem_q >= dsr_q;
  end

  assign out_free = !out_valid_o || out_pop_i;

  always_comb begin
    st_d = st_q;
    case (st_q)
      B_IDLE:  if (job_valid_i && any_in) st_d = B_MAC;
      B_MAC:   if (s_q == 4'd9) st_d = B_CHK;
      B_CHK: begin
        if (ks_q == '0 || neg || abs_a >= (abs_k << 8)) st_d = B_OUT;
        else st_d = B_DIV;
      end
      B_DIV:   if (bc_q == 3'd0) st_d = B_OUT;
      B_OUT:   if (out_free) st_d = has_next ? B_MAC : B_IDLE;
      default: st_d = B_IDLE;
    endcase
  end

  always_comb begin
    job_pop_o = 1'b0;
    load_out  = 1'b0;
    case (st_q)
      B_IDLE:  job_pop_o = job_valid_i;
      B_OUT:   load_out  = out_free;
      default: load_out  = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= B_IDLE;
      out_valid_o <= 1'b0;
    end else begin
      st_q <= st_d;
      if (load_out) out_valid_o <= 1'b1;
      else if (out_pop_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      B_IDLE: begin
        job_q <= job_i;
        p_q   <= first_p;
        s_q   <= '0;
        m_q   <= '0;
        n_q   <= '0;
        acc_q <= '0;
        ks_q  <= '0;
      end
      B_MAC: begin
        if (s_q != 4'd9) begin
          prod_q <= prod_d;
          ks_q   <= ks_q + KS_W'(coef);
          if (n_q == 2'd2) begin
            n_q <= '0;
            m_q <= m_q + 2'd1;
          end else begin
            n_q <= n_q + 2'd1;
          end
        end
        if (s_q != 4'd0) acc_q <= acc_q + ACC_W'(prod_q);
        s_q <= s_q + 4'd1;
      end
      B_CHK: begin
        zs_q  <= ks_q == '0;
        px_q  <= '0;
        cl_q  <= 1'b0;
        rem_q <= abs_a;
        dsr_q <= abs_k << 7;
        bc_q  <= 3'd7;
        quo_q <= '0;
        if (ks_q != '0) begin
          if (neg) begin
            cl_q <= abs_a >= abs_k;
          end else if (abs_a >= (abs_k << 8)) begin
            px_q <= 8'd255;
            cl_q <= 1'b1;
          end
        end
      end
      B_DIV: begin
        if (rem_q >= dsr_q) rem_q <= rem_sub;
        quo_q <= quo_d;
        dsr_q <= dsr_q >> 1;
        bc_q  <= bc_q - 3'd1;
        if (bc_q == 3'd0) px_q <= quo_d;
      end
      B_OUT: begin
        if (out_free) begin
          p_q   <= next_p;
          s_q   <= '0;
          m_q   <= '0;
          n_q   <= '0;
          acc_q <= '0;
          ks_q  <= '0;
        end
      end
      default: begin
        s_q <= '0;
      end
    endcase
    if (load_out) begin
      pixel_o     <= px_q;
      zero_sum_o  <= zs_q;
      clipped_o   <= cl_q;
      last_o      <= !has_next;
      frame_end_o <= p_q == 2'd3;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/conv3x3_kernel_sum_normalized.sv -----
// The front reads the line buffer and pushes one window job per accepted pixel; then per
// result the back runs multiply-accumulate, a check step, the divider when the check does
// not settle the result, and an output step that waits until the output slot is free.
// Throughput is set by the single shared multiplier and the 8-step divider in the back.
// Reset clears the column and row counters, window, job FIFO and handshake state; line buffer contents stay undefined.
`default_nettype none
module conv3x3_kernel_sum_normalized #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  pixel_in_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       pixel_out_o,
  output logic             zero_sum_o,
  output logic             clipped_o,
  output logic             last_in_run_o,
  output logic             frame_end_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [47:0] cfg_wdata_i
);
  import c3ks_pkg::*;

  logic [CFG_W-1:0] coef_top_q, coef_mid_q, coef_bot_q;
  logic [WID_W-1:0] width_q;
  logic [HGT_W-1:0] height_q;
  logic             geom_clr;
  logic             job_push, fifo_full, job_pop, job_valid, out_valid;
  job_t             job_w, job_r;

  assign geom_clr = cfg_we_i && (cfg_idx_i == CFG_WIDTH || cfg_idx_i == CFG_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_top_q <= RST_COEF_TOP;
      coef_mid_q <= RST_COEF_MID;
      coef_bot_q <= RST_COEF_BOT;
      width_q    <= RST_WIDTH;
      height_q   <= RST_HEIGHT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_COEF_TOP: coef_top_q <= cfg_wdata_i;
        CFG_COEF_MID: coef_mid_q <= cfg_wdata_i;
        CFG_COEF_BOT: coef_bot_q <= cfg_wdata_i;
        CFG_WIDTH:    width_q    <= cfg_wdata_i[WID_W-1:0];
        CFG_HEIGHT:   height_q   <= cfg_wdata_i[HGT_W-1:0];
        default:      width_q    <= width_q;
      endcase
    end
  end

  c3ks_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .pixel_i     (pixel_in_i),
    .geom_clr_i  (geom_clr),
    .width_i     (width_q),
    .height_i    (height_q),
    .fifo_full_i (fifo_full),
    .job_push_o  (job_push),
    .job_o       (job_w)
  );

  c3ks_job_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (job_push),
    .wdata_i (job_w),
    .full_o  (fifo_full),
    .rd_i    (job_pop),
    .rdata_o (job_r),
    .valid_o (job_valid)
  );

  c3ks_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_top_i  (coef_top_q),
    .coef_mid_i  (coef_mid_q),
    .coef_bot_i  (coef_bot_q),
    .job_valid_i (job_valid),
    .job_i       (job_r),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid),
    .out_pop_i   (pop && out_valid),
    .pixel_o     (pixel_out_o),
    .zero_sum_o  (zero_sum_o),
    .clipped_o   (clipped_o),
    .last_o      (last_in_run_o),
    .frame_end_o (frame_end_o)
  );

  assign empty = !out_valid;

endmodule
`default_nettype wire
